### rtl/rgb_linear_contrast_stretch_core_defines.svh
// Assertion macros shared by the contrast stretch RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RGB_LINEAR_CONTRAST_STRETCH_CORE_DEFINES_SVH
`define RGB_LINEAR_CONTRAST_STRETCH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBLCS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rgblcs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBLCS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rgblcs: next-cycle check failed");

`endif

### rtl/rgblcs_pkg.sv
// Shared types, constants and the divider step for the contrast stretch core.
// Has no dependencies; every RTL module and interface uses it by scoped names.
package rgblcs_pkg;

    localparam int unsigned Channels   = 3;
    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned RegWidth   = Channels * ChanWidth;
    localparam int unsigned ProdWidth  = 2 * ChanWidth;
    localparam int unsigned DivStages  = ChanWidth / 2;
    localparam int unsigned LaneStages = DivStages + 2;
    localparam int unsigned PipeStages = LaneStages + 1;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned ShiftWidth = $clog2(ChanWidth);

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_IN_LOW   = 2'd0,
        REG_IN_HIGH  = 2'd1,
        REG_OUT_LOW  = 2'd2,
        REG_OUT_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REGION_LOW,
        REGION_LIN,
        REGION_HIGH
    } region_t;

    typedef struct packed {
        region_t                region;
        logic                   neg;
        logic [ChanWidth-1:0]   span;
        logic [ChanWidth-1:0]   nlo;
        logic [ChanWidth-1:0]   nhi;
    } lane_side_t;

    typedef struct packed {
        logic [PipeStages-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [ProdWidth-1:0] rem;
        logic [1:0]           qbits;
    } div_step_t;

    // Two restoring division steps for quotient bits sh and sh-1.
    function automatic div_step_t div_step2(
        input logic [ProdWidth-1:0]  rem,
        input logic [ChanWidth-1:0]  span,
        input logic [ShiftWidth-1:0] sh
    );
        div_step_t            res;
        logic [ProdWidth-1:0] d;
        res.rem   = rem;
        res.qbits = '0;
        for (int b = 1; b >= 0; b--)
        begin
            d = ProdWidth'(span) << (sh - ShiftWidth'(1 - b));
            if (res.rem >= d)
            begin
                res.rem      = res.rem - d;
                res.qbits[b] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

### rtl/rgblcs_pix_in_if.sv
// Request channel that carries one input pixel with valid/ready handshake.
// Depends on rgblcs_pkg for the channel width.
interface rgblcs_pix_in_if;
    logic                            valid;
    logic                            ready;
    logic [rgblcs_pkg::ChanWidth-1:0] red_in;
    logic [rgblcs_pkg::ChanWidth-1:0] green_in;
    logic [rgblcs_pkg::ChanWidth-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

### rtl/rgblcs_pix_out_if.sv
// Request channel that carries one stretched pixel with valid/ready handshake.
// Depends on rgblcs_pkg for the channel width.
interface rgblcs_pix_out_if;
    logic                            valid;
    logic                            ready;
    logic [rgblcs_pkg::ChanWidth-1:0] red_out;
    logic [rgblcs_pkg::ChanWidth-1:0] green_out;
    logic [rgblcs_pkg::ChanWidth-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

### rtl/rgblcs_lane.sv
// One color channel datapath: range compare, multiply, pipelined divide, result select.
// Depends on rgblcs_pkg; stage loads come from rgblcs_ctrl.
module rgblcs_lane (
    input  logic                             clk,
    input  rgblcs_pkg::pipe_ctrl_t           ctl,
    input  logic [rgblcs_pkg::ChanWidth-1:0] v,
    input  logic [rgblcs_pkg::ChanWidth-1:0] lo,
    input  logic [rgblcs_pkg::ChanWidth-1:0] hi,
    input  logic [rgblcs_pkg::ChanWidth-1:0] nlo,
    input  logic [rgblcs_pkg::ChanWidth-1:0] nhi,
    output logic [rgblcs_pkg::ChanWidth-1:0] res
);

    localparam int unsigned W  = rgblcs_pkg::ChanWidth;
    localparam int unsigned PW = rgblcs_pkg::ProdWidth;
    localparam int unsigned DS = rgblcs_pkg::DivStages;

    rgblcs_pkg::lane_side_t side1_reg;
    rgblcs_pkg::lane_side_t side1_next;
    logic [W-1:0]           diff_reg;
    logic [W-1:0]           diff_next;
    logic [W-1:0]           off_reg;
    logic [W-1:0]           off_next;

    rgblcs_pkg::lane_side_t side_reg [DS+1];
    logic [PW-1:0]          rem_reg  [DS+1];
    logic [W-1:0]           q_reg    [DS+1];

    rgblcs_pkg::lane_side_t fin;

    always_comb
    begin
        side1_next.neg  = (nhi < nlo);
        side1_next.span = hi - lo;
        side1_next.nlo  = nlo;
        side1_next.nhi  = nhi;
        priority if (v <= lo)
        begin
            side1_next.region = rgblcs_pkg::REGION_LOW;
        end
        else if (v <= hi)
        begin
            side1_next.region = rgblcs_pkg::REGION_LIN;
        end
        else
        begin
            side1_next.region = rgblcs_pkg::REGION_HIGH;
        end
        diff_next = side1_next.neg ? (nlo - nhi) : (nhi - nlo);
        off_next  = v - lo;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            side1_reg <= side1_next;
            diff_reg  <= diff_next;
            off_reg   <= off_next;
        end
        if (ctl.load[1])
        begin
            side_reg[0] <= side1_reg;
            rem_reg[0]  <= PW'(diff_reg) * PW'(off_reg);
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 1; j <= DS; j++)
    begin : g_div
        rgblcs_pkg::div_step_t st;

        assign st = rgblcs_pkg::div_step2(rem_reg[j-1], side_reg[j-1].span,
                                          rgblcs_pkg::ShiftWidth'(W + 1 - 2 * j));

        always_ff @(posedge clk)
        begin
            if (ctl.load[j+1])
            begin
                side_reg[j] <= side_reg[j-1];
                rem_reg[j]  <= st.rem;
                q_reg[j]    <= {q_reg[j-1][W-3:0], st.qbits};
            end
        end
    end

    assign fin = side_reg[DS];

    always_comb
    begin
        unique case (fin.region)
            rgblcs_pkg::REGION_LOW:  res = fin.nlo;
            rgblcs_pkg::REGION_HIGH: res = fin.nhi;
            rgblcs_pkg::REGION_LIN:  res = fin.neg ? (fin.nlo - q_reg[DS])
                                                   : (fin.nlo + q_reg[DS]);
            default:                 res = fin.nlo;
        endcase
    end

endmodule

### rtl/rgblcs_ctrl.sv
// Valid tracking and per-stage load enables for the lane pipeline and output register.
// Depends on rgblcs_pkg and the assertion macro header.
`include "rgb_linear_contrast_stretch_core_defines.svh"

module rgblcs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rgblcs_pkg::pipe_ctrl_t ctl
);

    localparam int unsigned P = rgblcs_pkg::PipeStages;

    logic [P-1:0] valid_reg;
    logic [P-1:0] valid_next;
    logic [P-1:0] adv;
    logic [P-1:0] src;

    always_comb
    begin
        adv[P-1] = !valid_reg[P-1] || out_ready;
        for (int k = P - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        src        = {valid_reg[P-2:0], in_valid};
        valid_next = (adv & src) | (~adv & valid_reg);
        ctl.load   = adv & src;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[P-1];

    `RGBLCS_ASSERT_NEXT(a_stalled_stage_holds, 1'b1, ((valid_reg & $past(valid_reg & ~adv)) == $past(valid_reg & ~adv)))
    `RGBLCS_ASSERT_NOW(a_ready_when_room, !(&valid_reg), in_ready)
    `RGBLCS_ASSERT_NEXT(a_request_count, 1'b1, ($countones(valid_reg) == $countones($past(valid_reg)) + ($past(in_valid && in_ready) ? 1 : 0) - ($past(out_valid && out_ready) ? 1 : 0)))

endmodule

### rtl/rgb_linear_contrast_stretch_core.sv
// Top level of the RGB piecewise-linear contrast stretch: config registers,
// three channel lanes, pipeline control and the merged output register.
//
// Channel   Direction  Handshake      Payload
// pix_in    sink       valid/ready    red_in, green_in, blue_in (8 bits each)
// pix_out   source     valid/ready    red_out, green_out, blue_out (8 bits each)
// cfg       write      cfg_wr_en      cfg_index (2 bits), cfg_data (24 bits)
//
// One pixel request is accepted per clock while pix_in.ready is high. Each passes seven
// register stages: one compare stage, one multiply stage, four divide stages of two
// quotient bits each and the output register.
// A stalled output holds only the stages that are full; empty stages still fill.
// Reset clears the pipeline valid bits and all four range registers to zero.
module rgb_linear_contrast_stretch_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rgblcs_pix_in_if.sink                        pix_in,
    rgblcs_pix_out_if.source                     pix_out,
    input  logic                                 cfg_wr_en,
    input  logic [rgblcs_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [rgblcs_pkg::RegWidth-1:0]      cfg_data
);

    localparam int unsigned W  = rgblcs_pkg::ChanWidth;
    localparam int unsigned RW = rgblcs_pkg::RegWidth;
    localparam int unsigned NC = rgblcs_pkg::Channels;
    localparam int unsigned P  = rgblcs_pkg::PipeStages;

    logic [RW-1:0] in_low_reg;
    logic [RW-1:0] in_high_reg;
    logic [RW-1:0] out_low_reg;
    logic [RW-1:0] out_high_reg;

    rgblcs_pkg::pipe_ctrl_t ctl;
    logic [W-1:0]           pix_v   [NC];
    logic [W-1:0]           lane_res [NC];
    logic [W-1:0]           red_reg;
    logic [W-1:0]           green_reg;
    logic [W-1:0]           blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg   <= '0;
            in_high_reg  <= '0;
            out_low_reg  <= '0;
            out_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rgblcs_pkg::cfg_reg_t'(cfg_index))
                rgblcs_pkg::REG_IN_LOW:   in_low_reg   <= cfg_data;
                rgblcs_pkg::REG_IN_HIGH:  in_high_reg  <= cfg_data;
                rgblcs_pkg::REG_OUT_LOW:  out_low_reg  <= cfg_data;
                rgblcs_pkg::REG_OUT_HIGH: out_high_reg <= cfg_data;
                default:                  in_low_reg   <= in_low_reg;
            endcase
        end
    end

    rgblcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .ctl       (ctl)
    );

    assign pix_v[0] = pix_in.red_in;
    assign pix_v[1] = pix_in.green_in;
    assign pix_v[2] = pix_in.blue_in;

    for (genvar g = 0; g < NC; g++)
    begin : g_lane
        rgblcs_lane u_lane (
            .clk (clk),
            .ctl (ctl),
            .v   (pix_v[g]),
            .lo  (in_low_reg[g*W +: W]),
            .hi  (in_high_reg[g*W +: W]),
            .nlo (out_low_reg[g*W +: W]),
            .nhi (out_high_reg[g*W +: W]),
            .res (lane_res[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[P-1])
        begin
            red_reg   <= lane_res[0];
            green_reg <= lane_res[1];
            blue_reg  <= lane_res[2];
        end
    end

    assign pix_out.red_out   = red_reg;
    assign pix_out.green_out = green_reg;
    assign pix_out.blue_out  = blue_reg;

endmodule

### tb/rgb_linear_contrast_stretch_core_checker.sv
`timescale 1ns / 100ps
// Checker for the RGB contrast stretch core: watches the pixel channels and the
// configuration port, predicts each stretched pixel and compares it on output.
// Depends on rgblcs_pkg and the two pixel channel interfaces.
module rgb_linear_contrast_stretch_core_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rgblcs_pix_in_if                             pix_in,
    rgblcs_pix_out_if                            pix_out,
    input  logic                                 cfg_wr_en,
    input  logic [rgblcs_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [rgblcs_pkg::RegWidth-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    typedef logic [rgblcs_pkg::Channels-1:0][rgblcs_pkg::ChanWidth-1:0] pixel_t;

    pixel_t src_low;
    pixel_t src_high;
    pixel_t dst_low;
    pixel_t dst_high;
    pixel_t expected_pixels[$];

    string channel_names[rgblcs_pkg::Channels] = '{"red", "green", "blue"};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_low  <= '0;
            src_high <= '0;
            dst_low  <= '0;
            dst_high <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (rgblcs_pkg::cfg_reg_t'(cfg_index))
                rgblcs_pkg::REG_IN_LOW:   src_low  <= cfg_data;
                rgblcs_pkg::REG_IN_HIGH:  src_high <= cfg_data;
                rgblcs_pkg::REG_OUT_LOW:  dst_low  <= cfg_data;
                rgblcs_pkg::REG_OUT_HIGH: dst_high <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [rgblcs_pkg::ChanWidth-1:0] stretch_channel(
        input int v, input int lo, input int hi, input int nlo, input int nhi);
        int r;
        if (v <= lo)
            r = nlo;
        else if (v <= hi)
            r = nlo + ((nhi - nlo) * (v - lo)) / (hi - lo);
        else
            r = nhi;
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return r[rgblcs_pkg::ChanWidth-1:0];
    endfunction

    function automatic pixel_t stretch_pixel(input pixel_t px);
        pixel_t res;
        for (int ch = 0; ch < rgblcs_pkg::Channels; ch++)
        begin
            res[ch] = stretch_channel(int'(px[ch]), int'(src_low[ch]), int'(src_high[ch]),
                                      int'(dst_low[ch]), int'(dst_high[ch]));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: stretch mismatch: %s", $time, msg);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        checked    = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.blue_out, pix_out.green_out, pix_out.red_out};
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("pixel %0h with no request outstanding", got));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    for (int ch = 0; ch < rgblcs_pkg::Channels; ch++)
                    begin
                        if (got[ch] !== want[ch])
                            report_mismatch($sformatf("pixel %0d %s got %0d expected %0d",
                                                      checked, channel_names[ch],
                                                      got[ch], want[ch]));
                    end
                    checked++;
                end
            end
            if (pix_in.valid && pix_in.ready)
                expected_pixels.push_back(stretch_pixel({pix_in.blue_in, pix_in.green_in,
                                                         pix_in.red_in}));
        end
        pending <= expected_pixels.size();
    end

endmodule

### tb/rgb_linear_contrast_stretch_core_tb.sv
`timescale 1ns / 100ps
// Top of the contrast stretch testbench: clock, reset, range settings, pixel
// requests in bursts and a stalling receiver; depends on the core and the checker.
module rgb_linear_contrast_stretch_core_tb;

    localparam int CycleLimit   = 200000;
    localparam int RandomPhases = 8;
    localparam int PhaseItems   = 50;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [rgblcs_pkg::CfgIdxWidth-1:0] cfg_index;
    logic [rgblcs_pkg::RegWidth-1:0]    cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int sent;
    int settings;
    int burst_left;
    bit bursty;
    int stall_tick;
    int stall_mode;

    rgblcs_pix_in_if  pix_in ();
    rgblcs_pix_out_if pix_out ();

    rgb_linear_contrast_stretch_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgb_linear_contrast_stretch_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timed out after %0d cycles with %0d pixels outstanding.",
                     cycle_count, pending);
            $display("rgb_linear_contrast_stretch_core_tb: errors");
            $finish;
        end
    end

    // The receiver switches between always ready, two random stall rates and long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else
        begin
            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: pix_out.ready <= 1'b1;
                1: pix_out.ready <= 1'($urandom_range(0, 1));
                2: pix_out.ready <= ($urandom_range(0, 3) != 0);
                default: pix_out.ready <= ((stall_tick % 16) < 4);
            endcase
        end
    end

    task automatic send_pixel(input logic [rgblcs_pkg::ChanWidth-1:0] r,
                              input logic [rgblcs_pkg::ChanWidth-1:0] g,
                              input logic [rgblcs_pkg::ChanWidth-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                pix_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r;
        pix_in.green_in <= g;
        pix_in.blue_in  <= b;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic drain_pipeline();
        pix_in.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_ranges(input logic [rgblcs_pkg::RegWidth-1:0] il,
                                input logic [rgblcs_pkg::RegWidth-1:0] ih,
                                input logic [rgblcs_pkg::RegWidth-1:0] ol,
                                input logic [rgblcs_pkg::RegWidth-1:0] oh);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= rgblcs_pkg::REG_IN_LOW;
        cfg_data  <= il;
        @(posedge clk);
        cfg_index <= rgblcs_pkg::REG_IN_HIGH;
        cfg_data  <= ih;
        @(posedge clk);
        cfg_index <= rgblcs_pkg::REG_OUT_LOW;
        cfg_data  <= ol;
        @(posedge clk);
        cfg_index <= rgblcs_pkg::REG_OUT_HIGH;
        cfg_data  <= oh;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Values near the range bounds exercise the branch edges more than uniform values.
    function automatic logic [rgblcs_pkg::ChanWidth-1:0] pick_value(
        input logic [rgblcs_pkg::ChanWidth-1:0] lo,
        input logic [rgblcs_pkg::ChanWidth-1:0] hi);
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return lo;
            3: return lo + 8'd1;
            4: return hi;
            5: return hi + 8'd1;
            6: return hi - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        logic [rgblcs_pkg::RegWidth-1:0]  il;
        logic [rgblcs_pkg::RegWidth-1:0]  ih;
        logic [rgblcs_pkg::RegWidth-1:0]  ol;
        logic [rgblcs_pkg::RegWidth-1:0]  oh;
        logic [rgblcs_pkg::ChanWidth-1:0] a;
        logic [rgblcs_pkg::ChanWidth-1:0] z;
        for (int ch = 0; ch < rgblcs_pkg::Channels; ch++)
        begin
            a = 8'($urandom_range(0, 254));
            z = 8'($urandom_range(a + 1, 255));
            case ($urandom_range(0, 9))
                6: z = a;
                7: {a, z} = {z, a};
                8: {a, z} = {8'd0, 8'd255};
                9: {a, z} = {8'($urandom), 8'($urandom)};
                default: ;
            endcase
            il[ch*rgblcs_pkg::ChanWidth +: rgblcs_pkg::ChanWidth] = a;
            ih[ch*rgblcs_pkg::ChanWidth +: rgblcs_pkg::ChanWidth] = z;
            ol[ch*rgblcs_pkg::ChanWidth +: rgblcs_pkg::ChanWidth] =
                ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
            oh[ch*rgblcs_pkg::ChanWidth +: rgblcs_pkg::ChanWidth] =
                ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom);
        end
        write_ranges(il, ih, ol, oh);
        for (int i = 0; i < n_items; i++)
        begin
            send_pixel(pick_value(il[7:0], ih[7:0]), pick_value(il[15:8], ih[15:8]),
                       pick_value(il[23:16], ih[23:16]));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = rgblcs_pkg::REG_IN_LOW;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        pix_out.ready   = 1'b0;
        sent            = 0;
        settings        = 0;
        burst_left      = 0;
        bursty          = 1'b1;
        stall_tick      = 0;
        stall_mode      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All ranges zero after reset: zero span everywhere.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd1);

        // Red ordinary, green with a falling target, blue with a zero span.
        write_ranges(24'h641E32, 24'h64DCC8, 24'h00FA0A, 24'hFF05F0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd50, 8'd30, 8'd100);
        send_pixel(8'd51, 8'd31, 8'd101);
        send_pixel(8'd125, 8'd125, 8'd99);
        send_pixel(8'd200, 8'd220, 8'd255);
        send_pixel(8'd201, 8'd221, 8'd100);
        send_pixel(8'd255, 8'd255, 8'd1);

        // Red with an inverted source, green above both bounds, blue full and falling.
        write_ranges(24'h0000C8, 24'hFF6432, 24'hFF0014, 24'h0032B4);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd255);
        send_pixel(8'd201, 8'd200, 8'd128);
        send_pixel(8'd100, 8'd255, 8'd1);
        send_pixel(8'd255, 8'd101, 8'd254);

        // Full source range mapped onto a full falling target.
        write_ranges(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd15);

        // Both source bounds at their top: nothing can rise above the low bound.
        write_ranges(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);

        for (int p = 0; p < RandomPhases; p++)
        begin
            bursty = (p % 3 != 0);
            random_phase(PhaseItems);
        end

        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d pixels under %0d range settings besides reset; %0d results checked.",
                 sent, settings, checked);
        $display("Directed edges, zero spans, inverted ranges and random bursts with stalls.");
        if (fail_count == 0)
            $display("rgb_linear_contrast_stretch_core_tb: clean");
        else
            $display("rgb_linear_contrast_stretch_core_tb: errors");
        $finish;
    end

endmodule
